@@ design/ffha_pkg.sv @@
// ----------------------------------------------------------------------------
// ffha_pkg : shared types for the first-fit heap allocator
// Request and response layouts, action and status codes, header field layout.
// ----------------------------------------------------------------------------
package ffha_pkg;

    localparam int SIZE_W = 15;   // header size field, in granules
    localparam int HDR_W  = 16;   // header word: alloc mark + size

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOINIT  = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_BADADDR = 2'd3;

    typedef struct packed {
        logic        action;
        logic [15:0] request_size;
        logic [31:0] block_address;
    } t_req;

    typedef struct packed {
        logic [31:0] result_address;
        logic [1:0]  status;
    } t_resp;

endpackage

@@ design/first_fit_heap_allocator.sv @@
// ----------------------------------------------------------------------------
// first_fit_heap_allocator : first-fit allocator over an on-chip header store
// Implicit free list walked one header per cycle by a small sequencer.
// ----------------------------------------------------------------------------
// One request at a time. An allocate is accepted, checks its size and reads
// granule 0, then walks the headers up to the chosen block; a split or a tail
// allocation adds a second header write. The walk is bound by the single read
// port of the header store, one header read per cycle through one shared adder
// that forms the next header index. A free passes accept, address check with
// header read, header write and response. A zero heap_base sends a request
// from accept to the response; an allocate too large to encode is refused at
// the size check. The response sits in an output register, so the response
// side may stall; a new request is taken only once the previous response has
// been loaded there. The header store needs no clearing pass: only granule 0
// is defined after reset (a free end marker), and a flag makes it read as zero
// until it is first written. The user is to write heap_base through the config
// port only while the block is idle; the block does not enforce it. Zero means
// not initialised and every request then returns status 1.
module first_fit_heap_allocator #(
    parameter int HEAP_GRANULES = 32768,
    parameter int HEADER_BYTES  = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    // request channel
    input  logic            i_req_valid,
    output logic            o_req_stall,
    input  ffha_pkg::t_req  i_req,
    // response channel
    output logic            o_rsp_valid,
    input  logic            i_rsp_stall,
    output ffha_pkg::t_resp o_rsp,
    // config
    input  logic            i_cfg_wr_en,
    input  logic [31:0]     i_cfg_wr_data
);
    import ffha_pkg::*;

    localparam int HDR_G = (HEADER_BYTES + 1) / 2;          // header in granules
    localparam int IW    = $clog2(HEAP_GRANULES);           // store index width
    localparam int CW    = ((IW > SIZE_W) ? IW : SIZE_W) + 2; // walk cursor width

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC,
        S_WALK,
        S_SPLIT,
        S_FREE,
        S_CLEAR,
        S_DONE
    } t_state;

    // header store
    logic [HDR_W-1:0] r_mem [HEAP_GRANULES];
    logic [HDR_W-1:0] r_rd_data;
    logic             r_rd_blank;   // last read hit granule 0 before any write
    logic             r_hdr0_vld;

    // sequencer registers
    t_state            r_state,    n_state;
    logic [31:0]       r_base;
    logic [15:0]       r_size,     n_size;
    logic [31:0]       r_addr,     n_addr;
    logic [SIZE_W-1:0] r_need,     n_need;
    logic [CW-1:0]     r_cur,      n_cur;
    logic [IW-1:0]     r_wr2_addr, n_wr2_addr;
    logic [HDR_W-1:0]  r_wr2_data, n_wr2_data;
    t_resp             r_res,      n_res;
    logic              r_out_vld,  n_out_vld;
    t_resp             r_out,      n_out;

    // memory port controls
    logic             w_rd_en;
    logic [IW-1:0]    w_rd_addr;
    logic             w_we;
    logic [IW-1:0]    w_wa;
    logic [HDR_W-1:0] w_wd;

    // walk datapath
    logic [HDR_W-1:0]  w_hdr;
    logic [SIZE_W-1:0] w_g;
    logic              w_skip;
    logic [CW-1:0]     w_cur_hdr;
    logic [SIZE_W-1:0] w_step;
    logic [CW-1:0]     w_sum;       // shared adder: next header or split point
    logic [15:0]       w_need16;
    logic [31:0]       w_res_addr;

    // free address check
    logic [31:0] w_off;
    logic [30:0] w_half;
    logic [30:0] w_idx;
    logic        w_bad;

    assign o_req_stall = (r_state != S_IDLE);
    assign o_rsp_valid = r_out_vld;
    assign o_rsp       = r_out;

    // Header as seen by the walk; granule 0 reads as a free end marker until
    // it is first written.
    assign w_hdr     = r_rd_blank ? '0 : r_rd_data;
    assign w_g       = w_hdr[SIZE_W-1:0];
    assign w_skip    = (w_g != '0) && (w_hdr[HDR_W-1] || (w_g < r_need));
    assign w_cur_hdr = r_cur + CW'(HDR_G);
    assign w_step    = w_skip ? w_g : r_need;
    assign w_sum     = w_cur_hdr + CW'(w_step);
    assign w_res_addr = r_base + 32'({w_cur_hdr, 1'b0});

    // Round the byte count up to whole granules, at least one.
    assign w_need16 = 16'((17'(r_size) + 17'd1) >> 1);

    assign w_off  = r_addr - r_base;
    assign w_half = w_off[31:1];
    assign w_idx  = w_half - 31'(HDR_G);
    assign w_bad  = w_off[0] || (w_half < 31'(HDR_G)) || (w_idx >= 31'(HEAP_GRANULES));

    always_comb begin
        n_state    = r_state;
        n_size     = r_size;
        n_addr     = r_addr;
        n_need     = r_need;
        n_cur      = r_cur;
        n_wr2_addr = r_wr2_addr;
        n_wr2_data = r_wr2_data;
        n_res      = r_res;
        n_out_vld  = r_out_vld;
        n_out      = r_out;
        w_rd_en    = 1'b0;
        w_rd_addr  = '0;
        w_we       = 1'b0;
        w_wa       = r_cur[IW-1:0];
        w_wd       = '0;

        if (r_out_vld && !i_rsp_stall) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_size = i_req.request_size;
                    n_addr = i_req.block_address;
                    if (r_base == '0) begin
                        n_res   = '{result_address: '0, status: ST_NOINIT};
                        n_state = S_DONE;
                    end else if (i_req.action == ACT_FREE) begin
                        n_state = S_FREE;
                    end else begin
                        n_state = S_ALLOC;
                    end
                end
            end
            S_ALLOC: begin
                if (w_need16 > 16'(2**SIZE_W - 1)) begin
                    n_res   = '{result_address: '0, status: ST_FULL};
                    n_state = S_DONE;
                end else begin
                    n_need    = (w_need16 == '0) ? SIZE_W'(1) : w_need16[SIZE_W-1:0];
                    n_cur     = '0;
                    w_rd_en   = 1'b1;
                    w_rd_addr = '0;
                    n_state   = S_WALK;
                end
            end
            S_WALK: begin
                if (w_skip) begin
                    if (w_sum >= CW'(HEAP_GRANULES)) begin
                        n_res   = '{result_address: '0, status: ST_FULL};
                        n_state = S_DONE;
                    end else begin
                        n_cur     = w_sum;
                        w_rd_en   = 1'b1;
                        w_rd_addr = w_sum[IW-1:0];
                    end
                end else if (w_g == '0) begin
                    // tail allocation: new end marker after the block
                    if (w_sum >= CW'(HEAP_GRANULES)) begin
                        n_res   = '{result_address: '0, status: ST_FULL};
                        n_state = S_DONE;
                    end else begin
                        w_we       = 1'b1;
                        w_wd       = {1'b1, r_need};
                        n_wr2_addr = w_sum[IW-1:0];
                        n_wr2_data = '0;
                        n_res      = '{result_address: w_res_addr, status: ST_OK};
                        n_state    = S_SPLIT;
                    end
                end else if (17'(w_g) > 17'(r_need) + 17'(HDR_G)) begin
                    // split: remainder past its own header becomes free
                    w_we       = 1'b1;
                    w_wd       = {1'b1, r_need};
                    n_wr2_addr = w_sum[IW-1:0];
                    n_wr2_data = {1'b0, SIZE_W'(w_g - r_need - SIZE_W'(HDR_G))};
                    n_res      = '{result_address: w_res_addr, status: ST_OK};
                    n_state    = S_SPLIT;
                end else begin
                    // near fit: take the whole block
                    w_we    = 1'b1;
                    w_wd    = {1'b1, w_g};
                    n_res   = '{result_address: w_res_addr, status: ST_OK};
                    n_state = S_DONE;
                end
            end
            S_SPLIT: begin
                w_we    = 1'b1;
                w_wa    = r_wr2_addr;
                w_wd    = r_wr2_data;
                n_state = S_DONE;
            end
            S_FREE: begin
                if (w_bad) begin
                    n_res   = '{result_address: '0, status: ST_BADADDR};
                    n_state = S_DONE;
                end else begin
                    n_cur     = CW'(w_idx[IW-1:0]);
                    w_rd_en   = 1'b1;
                    w_rd_addr = w_idx[IW-1:0];
                    n_state   = S_CLEAR;
                end
            end
            S_CLEAR: begin
                w_we    = 1'b1;
                w_wd    = {1'b0, w_g};
                n_res   = '{result_address: '0, status: ST_OK};
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_vld || !i_rsp_stall) begin
                    n_out     = r_res;
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_base    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            if (i_cfg_wr_en) begin
                r_base <= i_cfg_wr_data;
            end
        end
        r_size     <= n_size;
        r_addr     <= n_addr;
        r_need     <= n_need;
        r_cur      <= n_cur;
        r_wr2_addr <= n_wr2_addr;
        r_wr2_data <= n_wr2_data;
        r_res      <= n_res;
        r_out      <= n_out;
    end

    // header store: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr0_vld <= 1'b0;
            r_rd_blank <= 1'b0;
        end else begin
            if (w_we && (w_wa == '0)) begin
                r_hdr0_vld <= 1'b1;
            end
            if (w_rd_en) begin
                r_rd_blank <= (w_rd_addr == '0) && !r_hdr0_vld;
            end
        end
    end

endmodule
